FILE: hdl/lxy_pkg.sv
// shared types, constants and helpers for the lissajous point generator
package lxy_pkg;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } arith_op_e;

  // request into the shared multiply / divide unit
  typedef struct packed {
    logic        start;
    arith_op_e   op;
    logic [63:0] opa;
    logic [31:0] opb;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } arith_rsp_t;

  // quotient bits retired per divider cycle
  localparam int DivStepBits = 4;

  // pi in q60, split into halves for the 32-bit multiplier
  localparam logic [31:0] PiHi     = 32'h3243_F6A8;
  localparam logic [31:0] PiLo     = 32'h885A_308D;
  localparam logic [63:0] OneQ60   = 64'h1000_0000_0000_0000;
  localparam logic [5:0]  MaxDots  = 6'd63;
  localparam logic [4:0]  TermLimit = 5'd24;

  // integer factor of series term k: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
  function automatic logic [11:0] term_div(input logic [4:0] k, input logic want_sin);
    logic [5:0]  k2;
    logic [11:0] fa;
    logic [11:0] fb;
    k2 = {k, 1'b0};
    if (want_sin) begin
      fa = {6'd0, k2};
      fb = {6'd0, k2 + 6'd1};
    end else begin
      fa = {6'd0, k2 - 6'd1};
      fb = {6'd0, k2};
    end
    return fa * fb;
  endfunction

endpackage

FILE: hdl/lxy_arith.sv
// shared 32x32 multiplier and radix-16 divider used by the point sequencer
module lxy_arith
  import lxy_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  arith_req_t req_i,
  output arith_rsp_t rsp_o
);

  localparam int Steps  = 64 / DivStepBits;
  localparam int CntW   = $clog2(Steps);

  logic                   run_q;
  logic                   done_q;
  logic [CntW-1:0]        cnt_q;
  logic [63:0]            work_q;
  logic [14:0]            rem_q;
  logic [14:0]            dsr_q;
  logic [DivStepBits-1:0] qbits;
  logic [14:0]            rem_next;
  logic [15:0]            trial;
  logic [63:0]            prod;

  assign prod = req_i.opa[31:0] * req_i.opb;

  // a few restoring steps per cycle, dividend bits taken from the top of work_q
  always_comb begin
    rem_next = rem_q;
    qbits    = '0;
    trial    = '0;
    for (int j = 0; j < DivStepBits; j++) begin
      trial = {rem_next, work_q[63-j]};
      if (trial >= {1'b0, dsr_q}) begin
        trial = trial - {1'b0, dsr_q};
        qbits[DivStepBits-1-j] = 1'b1;
      end
      rem_next = trial[14:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (req_i.op == OP_MUL) begin
          done_q <= 1'b1;
        end else begin
          run_q <= 1'b1;
          cnt_q <= '0;
        end
      end else if (run_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(Steps - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      if (req_i.op == OP_MUL) begin
        work_q <= prod;
      end else begin
        work_q <= req_i.opa;
        rem_q  <= '0;
        dsr_q  <= req_i.opb[14:0];
      end
    end else if (run_q) begin
      work_q <= {work_q[63-DivStepBits:0], qbits};
      rem_q  <= rem_next;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = work_q;

endmodule

FILE: hdl/lissajous_xy_point_generator.sv
// Lissajous point generator. Each frame tick advances a 32-bit phase accumulator by
// elapsed_ms * phase_per_ms (unless hold is set) and then produces dots_per_frame + 1
// points, the last repeating the first with last_point set. The products and divisions
// go through one shared unit: a 32x32 multiplier and a 4-bit-per-cycle divider. A
// cosine is a q60 Taylor series that stops when a term reaches zero or k reaches
// TermLimit; a full frame holds at most 64 points. The tick channel is stalled from
// acceptance until the closing point has been transferred; each point waits in the
// output register until taken.
module lissajous_xy_point_generator
  import lxy_pkg::*;
#(
  parameter int PHASE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         elapsed_ms_i,
  input  logic                hold_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [13:0]  screen_x_o,
  output logic signed [13:0]  screen_y_o,
  output logic                last_point_o,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_index_i,
  input  logic [31:0]         cfg_wdata_i
);

  localparam int PB   = PHASE_BITS;
  localparam int XShl = 33 - PB;
  localparam int XShr = PB - 1;

  localparam logic [PB-3:0] Eighth  = {1'b1, {(PB-3){1'b0}}};
  localparam logic [PB-2:0] Quarter = {1'b1, {(PB-2){1'b0}}};

  typedef enum logic [3:0] {
    REG_AMP_X    = 4'd0,
    REG_AMP_Y    = 4'd1,
    REG_FREQ_X   = 4'd2,
    REG_FREQ_Y   = 4'd3,
    REG_DOTS     = 4'd4,
    REG_PHASE_MS = 4'd5,
    REG_CENTER_X = 4'd6,
    REG_CENTER_Y = 4'd7
  } reg_idx_e;

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_DRIFT     = 16'h0002,
    S_DOT_DIV   = 16'h0004,
    S_ARG_MUL   = 16'h0008,
    S_COS_SETUP = 16'h0010,
    S_X_HI      = 16'h0020,
    S_X_LO      = 16'h0040,
    S_QMUL      = 16'h0080,
    S_TERM_CHK  = 16'h0100,
    S_TERM_DIV  = 16'h0200,
    S_ROUND1    = 16'h0400,
    S_ROUND2    = 16'h0800,
    S_SCALE_MUL = 16'h1000,
    S_SCALE_DIV = 16'h2000,
    S_EMIT      = 16'h4000,
    S_CLOSE     = 16'h8000
  } state_e;

  // configuration
  logic [11:0] amp_x_q, amp_y_q, cx_q, cy_q;
  logic [3:0]  freq_x_q, freq_y_q;
  logic [5:0]  dots_cfg_q;
  logic [31:0] ppm_q;

  // control
  state_e      state_q, state_d;
  logic        wait_q, wait_d;
  logic [31:0] drift_q, drift_d;
  logic [5:0]  dots_q, dots_d;
  logic [5:0]  idx_q, idx_d;
  logic        axis_x_q, axis_x_d;
  logic [1:0]  step_q, step_d;
  logic [4:0]  k_q, k_d;
  logic        for_term_q, for_term_d;

  // datapath
  logic [15:0]  elapsed_q;
  logic         hold_q;
  logic [PB-1:0] dph_q, dph_d;
  logic [PB-1:0] p_q, p_d;
  logic         neg_q, neg_d;
  logic         ws_q, ws_d;
  logic [PB-3:0] rr_q, rr_d;
  logic [63:0]  xa_q, xa_d;
  logic [63:0]  x_q, x_d;
  logic [63:0]  x2_q, x2_d;
  logic [63:0]  term_q, term_d;
  logic [63:0]  sum_q, sum_d;
  logic [63:0]  ma_q, ma_d;
  logic [63:0]  mb_q, mb_d;
  logic [127:0] acc_q, acc_d;
  logic [58:0]  t_q, t_d;
  logic [14:0]  mag_q, mag_d;
  logic [27:0]  num_q, num_d;
  logic [13:0]  out_x_q, out_x_d;
  logic [13:0]  out_y_q, out_y_d;
  logic         last_q, last_d;
  logic [13:0]  x0_q, x0_d;
  logic [13:0]  y0_q, y0_d;

  arith_req_t req;
  arith_rsp_t rsp;

  logic [PB-1:0] ph;
  logic [5:0]    dots_eff;
  logic [127:0]  pp_sh;
  logic [127:0]  acc_sum;
  logic [PB-3:0] r_part;
  logic [PB-2:0] r_mirror;
  logic [43:0]   s_top;
  logic [58:0]   t_round;
  logic [27:0]   scale_sum;
  logic [13:0]   sv;
  logic [13:0]   coord;

  lxy_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign ph = drift_q[31 -: PB];

  always_comb begin
    if (dots_cfg_q == 6'd0) begin
      dots_eff = 6'd1;
    end else if (dots_cfg_q > MaxDots) begin
      dots_eff = MaxDots;
    end else begin
      dots_eff = dots_cfg_q;
    end
  end

  // partial products of the q60 multiply: lo*lo, hi*lo, lo*hi, hi*hi
  always_comb begin
    case (step_q)
      2'd0:    pp_sh = {64'd0, rsp.result};
      2'd3:    pp_sh = {rsp.result, 64'd0};
      default: pp_sh = {32'd0, rsp.result, 32'd0};
    endcase
  end

  assign acc_sum  = acc_q + pp_sh;
  assign r_part   = p_q[PB-3:0];
  assign r_mirror = Quarter - {1'b0, r_part};
  assign s_top    = sum_q[63:20];
  assign t_round  = t_q + {20'd1, 39'd0};
  // n / 32767 as (n + n / 32768 + 1) / 32768, exact for n below 4096 * 32767
  assign scale_sum = num_q + {15'd0, num_q[27:15]} + 28'd1;
  assign sv       = neg_q ? (14'd0 - {2'd0, scale_sum[26:15]}) : {2'd0, scale_sum[26:15]};
  assign coord    = axis_x_q ? ({2'd0, cx_q} + sv) : ({2'd0, cy_q} - sv);

  always_comb begin
    state_d    = state_q;
    wait_d     = wait_q;
    drift_d    = drift_q;
    dots_d     = dots_q;
    idx_d      = idx_q;
    axis_x_d   = axis_x_q;
    step_d     = step_q;
    k_d        = k_q;
    for_term_d = for_term_q;
    dph_d      = dph_q;
    p_d        = p_q;
    neg_d      = neg_q;
    ws_d       = ws_q;
    rr_d       = rr_q;
    xa_d       = xa_q;
    x_d        = x_q;
    x2_d       = x2_q;
    term_d     = term_q;
    sum_d      = sum_q;
    ma_d       = ma_q;
    mb_d       = mb_q;
    acc_d      = acc_q;
    t_d        = t_q;
    mag_d      = mag_q;
    num_d      = num_q;
    out_x_d    = out_x_q;
    out_y_d    = out_y_q;
    last_d     = last_q;
    x0_d       = x0_q;
    y0_d       = y0_q;
    req.start  = 1'b0;
    req.op     = OP_MUL;
    req.opa    = '0;
    req.opb    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DRIFT;
        end
      end

      S_DRIFT: begin
        req.opa = {48'd0, elapsed_q};
        req.opb = ppm_q;
        if (!wait_q) begin
          req.start = 1'b1;
          wait_d    = 1'b1;
        end else if (rsp.done) begin
          wait_d   = 1'b0;
          if (!hold_q) begin
            drift_d = drift_q + rsp.result[31:0];
          end
          dots_d   = dots_eff;
          idx_d    = '0;
          axis_x_d = 1'b1;
          state_d  = S_DOT_DIV;
        end
      end

      S_DOT_DIV: begin
        req.op  = OP_DIV;
        req.opa = {{(58-PB){1'b0}}, idx_q, {PB{1'b0}}};
        req.opb = {26'd0, dots_q};
        if (!wait_q) begin
          req.start = 1'b1;
          wait_d    = 1'b1;
        end else if (rsp.done) begin
          wait_d  = 1'b0;
          dph_d   = rsp.result[PB-1:0];
          state_d = S_ARG_MUL;
        end
      end

      S_ARG_MUL: begin
        req.opa = {{(64-PB){1'b0}}, dph_q};
        req.opb = {28'd0, axis_x_q ? freq_x_q : freq_y_q};
        if (!wait_q) begin
          req.start = 1'b1;
          wait_d    = 1'b1;
        end else if (rsp.done) begin
          wait_d  = 1'b0;
          p_d     = rsp.result[PB-1:0] + (axis_x_q ? ph : '0);
          state_d = S_COS_SETUP;
        end
      end

      // octant reduction: fold onto [0, pi/4], swapping cosine and sine
      S_COS_SETUP: begin
        neg_d = p_q[PB-1] ^ p_q[PB-2];
        if (r_part <= Eighth) begin
          rr_d = r_part;
          ws_d = p_q[PB-2];
        end else begin
          rr_d = r_mirror[PB-3:0];
          ws_d = !p_q[PB-2];
        end
        state_d = S_X_HI;
      end

      S_X_HI: begin
        req.opa = {{(66-PB){1'b0}}, rr_q};
        req.opb = PiHi;
        if (!wait_q) begin
          req.start = 1'b1;
          wait_d    = 1'b1;
        end else if (rsp.done) begin
          wait_d  = 1'b0;
          xa_d    = rsp.result;
          state_d = S_X_LO;
        end
      end

      S_X_LO: begin
        req.opa = {{(66-PB){1'b0}}, rr_q};
        req.opb = PiLo;
        if (!wait_q) begin
          req.start = 1'b1;
          wait_d    = 1'b1;
        end else if (rsp.done) begin
          wait_d     = 1'b0;
          x_d        = (xa_q << XShl) + (rsp.result >> XShr);
          ma_d       = (xa_q << XShl) + (rsp.result >> XShr);
          mb_d       = (xa_q << XShl) + (rsp.result >> XShr);
          acc_d      = '0;
          step_d     = 2'd0;
          for_term_d = 1'b0;
          state_d    = S_QMUL;
        end
      end

      // q60 product over four 32x32 partial products
      S_QMUL: begin
        req.opa = {32'd0, step_q[0] ? ma_q[63:32] : ma_q[31:0]};
        req.opb = step_q[1] ? mb_q[63:32] : mb_q[31:0];
        if (!wait_q) begin
          req.start = 1'b1;
          wait_d    = 1'b1;
        end else if (rsp.done) begin
          wait_d = 1'b0;
          acc_d  = acc_sum;
          step_d = step_q + 2'd1;
          if (step_q == 2'd3) begin
            if (for_term_q) begin
              term_d  = acc_sum[123:60];
              state_d = S_TERM_DIV;
            end else begin
              x2_d    = acc_sum[123:60];
              term_d  = ws_q ? x_q : OneQ60;
              sum_d   = ws_q ? x_q : OneQ60;
              k_d     = 5'd1;
              state_d = S_TERM_CHK;
            end
          end
        end
      end

      S_TERM_CHK: begin
        if (term_q == 64'd0 || k_q == TermLimit) begin
          state_d = S_ROUND1;
        end else begin
          ma_d       = term_q;
          mb_d       = x2_q;
          acc_d      = '0;
          step_d     = 2'd0;
          for_term_d = 1'b1;
          state_d    = S_QMUL;
        end
      end

      S_TERM_DIV: begin
        req.op  = OP_DIV;
        req.opa = term_q;
        req.opb = {20'd0, term_div(k_q, ws_q)};
        if (!wait_q) begin
          req.start = 1'b1;
          wait_d    = 1'b1;
        end else if (rsp.done) begin
          wait_d = 1'b0;
          term_d = rsp.result;
          // alternating signs of the series
          if (k_q[0]) begin
            sum_d = sum_q - rsp.result;
          end else begin
            sum_d = sum_q + rsp.result;
          end
          k_d     = k_q + 5'd1;
          state_d = S_TERM_CHK;
        end
      end

      // times 32767 as shift and subtract
      S_ROUND1: begin
        t_d     = {s_top, 15'd0} - {15'd0, s_top};
        state_d = S_ROUND2;
      end

      S_ROUND2: begin
        mag_d   = t_round[54:40];
        state_d = S_SCALE_MUL;
      end

      S_SCALE_MUL: begin
        req.opa = {52'd0, axis_x_q ? amp_x_q : amp_y_q};
        req.opb = {17'd0, mag_q};
        if (!wait_q) begin
          req.start = 1'b1;
          wait_d    = 1'b1;
        end else if (rsp.done) begin
          wait_d  = 1'b0;
          num_d   = {1'b0, rsp.result[26:0]} + 28'd16383;
          state_d = S_SCALE_DIV;
        end
      end

      S_SCALE_DIV: begin
        if (axis_x_q) begin
          out_x_d  = coord;
          axis_x_d = 1'b0;
          state_d  = S_ARG_MUL;
        end else begin
          out_y_d = coord;
          last_d  = 1'b0;
          if (idx_q == 6'd0) begin
            x0_d = out_x_q;
            y0_d = coord;
          end
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 6'd1;
          if (idx_q + 6'd1 == dots_q) begin
            out_x_d = x0_q;
            out_y_d = y0_q;
            last_d  = 1'b1;
            state_d = S_CLOSE;
          end else begin
            axis_x_d = 1'b1;
            state_d  = S_DOT_DIV;
          end
        end
      end

      S_CLOSE: begin
        if (!out_stall_i) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_x_q    <= 12'd200;
      amp_y_q    <= 12'd270;
      freq_x_q   <= 4'd1;
      freq_y_q   <= 4'd1;
      dots_cfg_q <= 6'd60;
      ppm_q      <= 32'd1073742;
      cx_q       <= 12'd267;
      cy_q       <= 12'd300;
      state_q    <= S_IDLE;
      wait_q     <= 1'b0;
      drift_q    <= '0;
      dots_q     <= 6'd1;
      idx_q      <= '0;
      axis_x_q   <= 1'b1;
      step_q     <= '0;
      k_q        <= '0;
      for_term_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_AMP_X:    amp_x_q    <= cfg_wdata_i[11:0];
          REG_AMP_Y:    amp_y_q    <= cfg_wdata_i[11:0];
          REG_FREQ_X:   freq_x_q   <= cfg_wdata_i[3:0];
          REG_FREQ_Y:   freq_y_q   <= cfg_wdata_i[3:0];
          REG_DOTS:     dots_cfg_q <= cfg_wdata_i[5:0];
          REG_PHASE_MS: ppm_q      <= cfg_wdata_i;
          REG_CENTER_X: cx_q       <= cfg_wdata_i[11:0];
          REG_CENTER_Y: cy_q       <= cfg_wdata_i[11:0];
          default: ;
        endcase
      end
      state_q    <= state_d;
      wait_q     <= wait_d;
      drift_q    <= drift_d;
      dots_q     <= dots_d;
      idx_q      <= idx_d;
      axis_x_q   <= axis_x_d;
      step_q     <= step_d;
      k_q        <= k_d;
      for_term_q <= for_term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      elapsed_q <= elapsed_ms_i;
      hold_q    <= hold_i;
    end
    dph_q   <= dph_d;
    p_q     <= p_d;
    neg_q   <= neg_d;
    ws_q    <= ws_d;
    rr_q    <= rr_d;
    xa_q    <= xa_d;
    x_q     <= x_d;
    x2_q    <= x2_d;
    term_q  <= term_d;
    sum_q   <= sum_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    acc_q   <= acc_d;
    t_q     <= t_d;
    mag_q   <= mag_d;
    num_q   <= num_d;
    out_x_q <= out_x_d;
    out_y_q <= out_y_d;
    last_q  <= last_d;
    x0_q    <= x0_d;
    y0_q    <= y0_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_EMIT) || (state_q == S_CLOSE);
  assign screen_x_o   = out_x_q;
  assign screen_y_o   = out_y_q;
  assign last_point_o = last_q;

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the lissajous point generator: directed and random frame ticks
module tb_top;

  typedef enum logic [3:0] {
    REG_AMP_X,
    REG_AMP_Y,
    REG_FREQ_X,
    REG_FREQ_Y,
    REG_DOTS,
    REG_PHASE_STEP,
    REG_CENTER_X,
    REG_CENTER_Y
  } cfg_reg_e;

  localparam int NumRegs = 8;
  localparam logic [63:0] PiQ60 = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] UnitQ60 = 64'h1000_0000_0000_0000;
  localparam int SettleCycles = 1500;
  localparam int HoldOffCycles = 3000;

  typedef struct packed {
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic               last;
  } screen_point_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [15:0]        elapsed_ms_i;
  logic               hold_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [13:0] screen_x_o;
  logic signed [13:0] screen_y_o;
  logic               last_point_o;
  logic               cfg_we_i;
  logic [3:0]         cfg_index_i;
  logic [31:0]        cfg_wdata_i;

  // predictor copy of the block's registers and phase accumulator
  logic [11:0] amp_x_r, amp_y_r, center_x_r, center_y_r;
  logic [3:0]  freq_x_r, freq_y_r;
  logic [5:0]  dots_r;
  logic [31:0] phase_step_r;
  logic [31:0] drift_acc;

  screen_point_t pending_points[$];
  int fail_count;
  int ticks_sent;
  int points_seen;
  int cfg_phases;
  bit quiet;
  int rx_hold_len;

  lissajous_xy_point_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .elapsed_ms_i (elapsed_ms_i),
    .hold_i       (hold_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .screen_x_o   (screen_x_o),
    .screen_y_o   (screen_y_o),
    .last_point_o (last_point_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // (a * b) >> 60
  function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // rounded 32767 * cos or sin of an angle of at most an eighth turn
  function automatic int taylor_mag(input logic [31:0] r, input bit sine);
    logic [63:0] rr, x, x2, term, sum, div, mag;
    rr = {32'd0, r};
    x = ((rr * {32'd0, PiQ60[63:32]}) << 17) + ((rr * {32'd0, PiQ60[31:0]}) >> 15);
    x2 = q60_product(x, x);
    term = sine ? x : UnitQ60;
    sum = term;
    for (int k = 1; k < 24 && term != 0; k++) begin
      div = sine ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
      term = q60_product(term, x2) / div;
      if ((k % 2) != 0) sum = sum - term;
      else sum = sum + term;
    end
    mag = (((sum >> 20) * 64'd32767) + (64'd1 << 39)) >> 40;
    return int'(mag[31:0]);
  endfunction

  function automatic int fixed_cos(input logic [15:0] p);
    logic [1:0]  quad;
    logic [31:0] r;
    int          mag;
    quad = p[15:14];
    r = {18'd0, p[13:0]};
    if (r <= 32'd8192) mag = taylor_mag(r, quad[0]);
    else mag = taylor_mag(32'd16384 - r, !quad[0]);
    return (quad == 2'd1 || quad == 2'd2) ? -mag : mag;
  endfunction

  function automatic int scaled(input logic [11:0] amp, input int c);
    int m, v;
    m = (c < 0) ? -c : c;
    v = (int'(amp) * m + 16383) / 32767;
    return (c < 0) ? -v : v;
  endfunction

  task automatic predict_frame(input logic [15:0] elapsed, input logic hold);
    int dots, d, sx, sy;
    logic [15:0] ph;
    screen_point_t pt, first;
    if (!hold) drift_acc = drift_acc + elapsed * phase_step_r;
    ph = drift_acc[31:16];
    dots = (dots_r == 6'd0) ? 1 : int'(dots_r);
    first = '0;
    for (int i = 0; i < dots; i++) begin
      d = (i << 16) / dots;
      sx = int'(center_x_r) + scaled(amp_x_r, fixed_cos(16'(freq_x_r * d + ph)));
      sy = int'(center_y_r) - scaled(amp_y_r, fixed_cos(16'(freq_y_r * d)));
      pt.x = sx[13:0];
      pt.y = sy[13:0];
      pt.last = 1'b0;
      if (i == 0) first = pt;
      pending_points.push_back(pt);
    end
    first.last = 1'b1;
    pending_points.push_back(first);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // result checker
  always @(posedge clk_i) begin : point_check
    screen_point_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      points_seen++;
      if (pending_points.size() == 0) begin
        note_failure($sformatf("unexpected point x=%0d y=%0d last=%0b",
                               screen_x_o, screen_y_o, last_point_o));
      end else begin
        want = pending_points.pop_front();
        if (screen_x_o !== want.x || screen_y_o !== want.y || last_point_o !== want.last)
          note_failure($sformatf(
            "point mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
            want.x, want.y, want.last, screen_x_o, screen_y_o, last_point_o));
      end
    end
  end

  // receiver: random stalls, optional long hold-off
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_len != 0) begin
        out_stall_i = 1'b1;
        repeat (rx_hold_len) @(negedge clk_i);
        rx_hold_len = 0;
      end
      out_stall_i = !quiet && ($urandom_range(99) < 15);
    end
  end

  initial begin
    #1_000_000_000;
    $display("lissajous_xy_point_generator regression: fail");
    $finish;
  end

  // expects to be called at a falling edge; returns at the falling edge after the transfer
  task automatic send_tick(input logic [15:0] elapsed, input logic hold);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    elapsed_ms_i = elapsed;
    hold_i = hold;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    predict_frame(elapsed, hold);
    ticks_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_points.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    case (idx)
      REG_AMP_X:      amp_x_r = data[11:0];
      REG_AMP_Y:      amp_y_r = data[11:0];
      REG_FREQ_X:     freq_x_r = data[3:0];
      REG_FREQ_Y:     freq_y_r = data[3:0];
      REG_DOTS:       dots_r = data[5:0];
      REG_PHASE_STEP: phase_step_r = data;
      REG_CENTER_X:   center_x_r = data[11:0];
      REG_CENTER_Y:   center_y_r = data[11:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    @(negedge clk_i);
  endtask

  // random bits above a field of the given width
  function automatic logic [31:0] with_junk(input logic [31:0] value, input int bits);
    return ($urandom() << bits) | value;
  endfunction

  task automatic set_shape(input logic [11:0] ax, input logic [11:0] ay,
                           input logic [3:0] fx, input logic [3:0] fy, input logic [5:0] dots);
    write_reg(REG_AMP_X, {20'd0, ax});
    write_reg(REG_AMP_Y, {20'd0, ay});
    write_reg(REG_FREQ_X, {28'd0, fx});
    write_reg(REG_FREQ_Y, {28'd0, fy});
    write_reg(REG_DOTS, {26'd0, dots});
    cfg_phases++;
  endtask

  task automatic test_reset_config();
    send_tick(16'd0, 1'b0);
    send_tick(16'd250, 1'b0);
    drain();
  endtask

  task automatic test_field_extremes();
    set_shape(12'd900, 12'd700, 4'd3, 4'd2, 6'd3);
    send_tick(16'd0, 1'b0);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'hFFFF, 1'b1);
    send_tick(16'd1, 1'b0);
    send_tick(16'd0, 1'b1);
    drain();
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    send_tick(16'hFFFF, 1'b0);
    drain();
    write_reg(REG_PHASE_STEP, 32'd0);
    send_tick(16'd12345, 1'b0);
    drain();
  endtask

  task automatic test_dot_counts();
    write_reg(REG_PHASE_STEP, 32'd1073742);
    // zero dots behaves as one dot
    set_shape(12'd300, 12'd300, 4'd1, 4'd1, 6'd0);
    send_tick(16'($urandom()), 1'b0);
    drain();
    write_reg(REG_DOTS, 32'd1);
    send_tick(16'($urandom()), 1'b0);
    drain();
    set_shape(12'd1000, 12'd800, 4'd7, 4'd5, 6'd63);
    send_tick(16'($urandom()), 1'b0);
    drain();
  endtask

  task automatic test_axis_extremes();
    // zero frequency keeps the axis term constant across the frame
    set_shape(12'd4095, 12'd4095, 4'd0, 4'd0, 6'd4);
    write_reg(REG_CENTER_X, 32'd0);
    write_reg(REG_CENTER_Y, 32'd0);
    send_tick(16'd777, 1'b0);
    drain();
    set_shape(12'd4095, 12'd4095, 4'd15, 4'd15, 6'd5);
    write_reg(REG_CENTER_X, 32'd4095);
    write_reg(REG_CENTER_Y, 32'd4095);
    send_tick(16'd31, 1'b0);
    drain();
    set_shape(12'd0, 12'd0, 4'd9, 4'd6, 6'd4);
    send_tick(16'd5000, 1'b0);
    drain();
    write_reg(REG_CENTER_X, 32'd0);
    write_reg(REG_CENTER_Y, 32'd4095);
    write_reg(REG_AMP_X, 32'd2047);
    write_reg(REG_AMP_Y, 32'd4095);
    send_tick(16'd64, 1'b0);
    drain();
  endtask

  task automatic test_unknown_regs();
    // writes to unused indexes must leave every register alone
    for (int i = NumRegs; i < 16; i++) write_reg(4'(i), $urandom());
    write_reg(REG_AMP_X, with_junk(32'd1234, 12));
    write_reg(REG_DOTS, with_junk(32'd2, 6));
    send_tick(16'd999, 1'b0);
    drain();
  endtask

  task automatic test_backpressure();
    set_shape(12'd600, 12'd500, 4'd2, 4'd3, 6'd4);
    write_reg(REG_PHASE_STEP, $urandom());
    rx_hold_len = HoldOffCycles;
    for (int i = 0; i < 3; i++) send_tick(16'($urandom()), 1'($urandom()));
    // sender waits for the whole backlog before the next transfer
    while (pending_points.size() != 0) @(negedge clk_i);
    send_tick(16'd10, 1'b0);
    drain();
  endtask

  task automatic test_random(input int phases, input int per_phase);
    logic [5:0] dots;
    logic [15:0] el;
    for (int ph = 0; ph < phases; ph++) begin
      quiet = (ph < 2);
      dots = ($urandom_range(19) == 0) ? 6'($urandom_range(63, 9)) : 6'($urandom_range(8, 0));
      write_reg(REG_AMP_X, with_junk($urandom_range(4095), 12));
      write_reg(REG_AMP_Y, with_junk($urandom_range(4095), 12));
      write_reg(REG_FREQ_X, with_junk($urandom_range(15), 4));
      write_reg(REG_FREQ_Y, with_junk($urandom_range(15), 4));
      write_reg(REG_DOTS, with_junk({26'd0, dots}, 6));
      write_reg(REG_PHASE_STEP, $urandom_range(1) ? $urandom() : $urandom_range(2000000));
      write_reg(REG_CENTER_X, with_junk($urandom_range(4095), 12));
      write_reg(REG_CENTER_Y, with_junk($urandom_range(4095), 12));
      if ($urandom_range(3) == 0) write_reg(4'($urandom_range(15, NumRegs)), $urandom());
      cfg_phases++;
      for (int i = 0; i < per_phase; i++) begin
        el = $urandom_range(1) ? 16'($urandom_range(50)) : 16'($urandom());
        send_tick(el, $urandom_range(99) < 20);
      end
      drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    elapsed_ms_i = '0;
    hold_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    quiet = 1'b0;
    rx_hold_len = 0;
    fail_count = 0;
    ticks_sent = 0;
    points_seen = 0;
    cfg_phases = 0;
    amp_x_r = 12'd200;
    amp_y_r = 12'd270;
    freq_x_r = 4'd1;
    freq_y_r = 4'd1;
    dots_r = 6'd60;
    phase_step_r = 32'd1073742;
    center_x_r = 12'd267;
    center_y_r = 12'd300;
    drift_acc = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_config();
    test_field_extremes();
    test_dot_counts();
    test_axis_extremes();
    test_unknown_regs();
    test_backpressure();
    test_random(9, 10);

    drain();
    repeat (SettleCycles) @(negedge clk_i);
    if (pending_points.size() != 0)
      note_failure($sformatf("%0d points never arrived", pending_points.size()));

    $display("covered %0d frame ticks, %0d points, %0d register settings incl. extremes",
             ticks_sent, points_seen, cfg_phases);
    $display("output hold-off of %0d cycles and unused register indexes exercised; %0d errors",
             HoldOffCycles, fail_count);
    if (fail_count == 0) begin
      $display("lissajous_xy_point_generator regression: pass");
    end else begin
      $display("lissajous_xy_point_generator regression: fail");
    end
    $finish;
  end

endmodule
